>>> hdl/text_terminal_cell_buffer_assert.svh
// Assertion macros shared by the terminal cell buffer RTL.
// Included by the modules that check their own logic; depends on nothing.
`ifndef TEXT_TERMINAL_CELL_BUFFER_ASSERT_SVH
`define TEXT_TERMINAL_CELL_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk, switched off while rst is high.
`define TTCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define TTCB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TTCB_ASSERT(label, prop, msg)
`define TTCB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> hdl/ttcb_pkg.sv
// Package of the terminal cell buffer: sizes, codes, command and state types.
// Depends on nothing; every module of the block but ttcb_ram imports it.
package ttcb_pkg;

  localparam int COLUMNS_DEF = 21;
  localparam int ROWS_DEF    = 8;
  localparam int COLUMNS_MAX = 64;
  localparam int ROWS_MAX    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int CMD_COL_W = $clog2(COLUMNS_MAX);
  localparam int CMD_ROW_W = $clog2(ROWS_MAX);
  localparam int MODE_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int IN_ROW_W  = 3;
  localparam int OUT_ROW_W = 3;
  localparam int OUT_COL_W = 5;

  // Input item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT     = 3'd0,
    MODE_REFRESH = 3'd1,
    MODE_SET_COL = 3'd2,
    MODE_SET_ROW = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_t;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_DELETE   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

  // Classified commands passed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_DELETE,
    OP_REFRESH,
    OP_SET_COL,
    OP_SET_ROW,
    OP_BAD_CURSOR,
    OP_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [CHAR_W-1:0]     ch;
    logic [CMD_ROW_W-1:0]  row;
    logic                  lazy;
    logic [CMD_COL_W-1:0]  val;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_WIPE,
    ST_REFRESH,
    ST_TAIL,
    ST_DRAIN
  } state_t;

endpackage

>>> hdl/ttcb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for both character stores.
module ttcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ttcb_front.sv
// Front end of the terminal cell buffer: takes items and turns them into commands.
// Depends on ttcb_pkg for the mode, character and command definitions.
module ttcb_front #(
  parameter int COLUMNS = ttcb_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcb_pkg::ROWS_DEF
) (
  input  logic                              start,
  input  logic [ttcb_pkg::MODE_W-1:0]       mode,
  input  logic [ttcb_pkg::CHAR_W-1:0]       char_code,
  input  logic [ttcb_pkg::IN_ROW_W-1:0]     row_index,
  input  logic                              lazy,
  input  logic signed [7:0]                 cursor_value,
  input  logic                              queue_full,
  input  logic                              init_busy,
  output logic                              busy,
  output logic                              push,
  output ttcb_pkg::cmd_t                    cmd
);

  import ttcb_pkg::*;

  logic       keep;
  logic [7:0] mag;

  assign mag = unsigned'(cursor_value);

  // Items that change nothing and give no result are taken and dropped here.
  always_comb begin
    cmd  = '0;
    keep = 1'b1;
    case (mode)
      MODE_PUT: begin
        if (char_code inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
          cmd.op = OP_PUT;
          cmd.ch = char_code;
        end else if (char_code == CH_NEWLINE) begin
          cmd.op = OP_NEWLINE;
        end else if (char_code == CH_RETURN) begin
          cmd.op = OP_RETURN;
        end else if (char_code == CH_DELETE) begin
          cmd.op = OP_DELETE;
        end else begin
          cmd.op = OP_PUT;
          cmd.ch = CH_SPACE;
        end
      end
      MODE_REFRESH: begin
        cmd.op   = OP_REFRESH;
        cmd.row  = CMD_ROW_W'(row_index);
        cmd.lazy = lazy;
        keep     = ({2'b00, row_index} < 5'(ROWS));
      end
      MODE_SET_COL: begin
        if (!mag[7] && (mag < 8'(COLUMNS))) begin
          cmd.op  = OP_SET_COL;
          cmd.val = CMD_COL_W'(mag);
        end else begin
          cmd.op = OP_BAD_CURSOR;
        end
      end
      MODE_SET_ROW: begin
        if (!mag[7] && (mag < 8'(ROWS))) begin
          cmd.op  = OP_SET_ROW;
          cmd.val = CMD_COL_W'(mag);
        end else begin
          cmd.op = OP_BAD_CURSOR;
        end
      end
      MODE_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy = queue_full || init_busy;
  assign push = start && !busy && keep;

endmodule

>>> hdl/ttcb_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on ttcb_pkg for the command type and on the assertion macro header.
`include "text_terminal_cell_buffer_assert.svh"
module ttcb_cmd_fifo #(
  parameter int DEPTH = ttcb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ttcb_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output ttcb_pkg::cmd_t dout,
  output logic           empty
);

  import ttcb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  `TTCB_ASSERT(a_no_overflow, push |-> !full, "command queue written while full")
  `TTCB_ASSERT(a_no_underflow, pop |-> !empty, "command queue read while empty")

endmodule

>>> hdl/ttcb_back.sv
// Back end of the terminal cell buffer: cursor, scrolling, stores and refresh.
// Depends on ttcb_pkg, ttcb_ram and the assertion macro header.
`include "text_terminal_cell_buffer_assert.svh"
module ttcb_back #(
  parameter int COLUMNS = ttcb_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcb_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  ttcb_pkg::cmd_t                 cmd,
  output logic                           pop,
  output logic                           init_busy,
  output logic                           strobe,
  output logic [ttcb_pkg::OUT_ROW_W-1:0] cell_row,
  output logic [ttcb_pkg::OUT_COL_W-1:0] cell_column,
  output logic [ttcb_pkg::CHAR_W-1:0]    cell_char,
  output logic                           status,
  output logic                           last
);

  import ttcb_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int SW    = RW + 1;

  // Text store rows are kept in a ring: logical row r lives in physical row
  // r + top, so a scroll only moves top and blanks one row.
  function automatic logic [RW-1:0] phys_of(input logic [RW-1:0] lrow,
                                            input logic [RW-1:0] base);
    logic [SW-1:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= SW'(ROWS)) begin
      sum = sum - SW'(ROWS);
    end
    phys_of = RW'(sum);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                            input logic [CW-1:0] c);
    addr_of = AW'(AW'(r) * AW'(COLUMNS)) + AW'(c);
  endfunction

  state_t state, state_next;

  logic [CW-1:0]     cur_col, cur_col_next;
  logic [RW-1:0]     cur_row, cur_row_next;
  logic [RW-1:0]     top, top_next;
  logic [AW-1:0]     sweep_addr, sweep_addr_next;
  logic [CW-1:0]     col_cnt, col_cnt_next;
  logic [RW-1:0]     ref_row, ref_row_next;
  logic              ref_lazy, ref_lazy_next;
  logic [AW-1:0]     cell_base, cell_base_next;
  logic [AW-1:0]     drawn_base, drawn_base_next;
  logic              rd_valid, rd_valid_next;
  logic [CW-1:0]     rd_col, rd_col_next;
  logic              pend_valid, pend_valid_next;
  logic [CW-1:0]     pend_col, pend_col_next;
  logic [CHAR_W-1:0] pend_char, pend_char_next;

  logic                 strobe_next;
  logic [OUT_ROW_W-1:0] cell_row_next;
  logic [OUT_COL_W-1:0] cell_column_next;
  logic [CHAR_W-1:0]    cell_char_next;
  logic                 status_next;
  logic                 last_next;

  logic              cell_we, drawn_we;
  logic [AW-1:0]     cell_waddr, drawn_waddr;
  logic [CHAR_W-1:0] cell_wdata, drawn_wdata;
  logic [AW-1:0]     cell_raddr, drawn_raddr;
  logic [CHAR_W-1:0] cell_rdata, drawn_rdata;

  logic          at_col_end;
  logic          at_row_end;
  logic          line_feed;
  logic          scroll_req;
  logic [CW-1:0] del_col;
  logic [RW-1:0] del_row;
  logic          hit;

  ttcb_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  ttcb_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_drawn_ram (
    .clk   (clk),
    .we    (drawn_we),
    .waddr (drawn_waddr),
    .wdata (drawn_wdata),
    .raddr (drawn_raddr),
    .rdata (drawn_rdata)
  );

  assign pop        = (state == ST_IDLE) && !empty;
  assign at_col_end = (cur_col == CW'(COLUMNS - 1));
  assign at_row_end = (cur_row == RW'(ROWS - 1));
  assign line_feed  = pop && (((cmd.op == OP_PUT) && at_col_end) || (cmd.op == OP_NEWLINE));
  assign scroll_req = line_feed && at_row_end;
  assign hit        = !ref_lazy || (cell_rdata != drawn_rdata);

  // Cursor position after a delete: one cell back, wrapping to the end of
  // the row above, and staying put at the home position.
  always_comb begin
    del_col = cur_col;
    del_row = cur_row;
    if (cur_col != '0) begin
      del_col = cur_col - 1'b1;
    end else if (cur_row != '0) begin
      del_col = CW'(COLUMNS - 1);
      del_row = cur_row - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT, ST_WIPE: begin
        if (sweep_addr == AW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          if (scroll_req) begin
            state_next = ST_SCROLL;
          end else if (cmd.op == OP_CLEAR) begin
            state_next = ST_WIPE;
          end else if (cmd.op == OP_REFRESH) begin
            state_next = ST_REFRESH;
          end
        end
      end
      ST_SCROLL: begin
        if (col_cnt == CW'(COLUMNS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_REFRESH: begin
        if (col_cnt == CW'(COLUMNS - 1)) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    top_next        = top;
    sweep_addr_next = sweep_addr;
    col_cnt_next    = col_cnt;
    ref_row_next    = ref_row;
    ref_lazy_next   = ref_lazy;
    cell_base_next  = cell_base;
    drawn_base_next = drawn_base;
    rd_valid_next   = 1'b0;
    rd_col_next     = rd_col;
    pend_valid_next = pend_valid;
    pend_col_next   = pend_col;
    pend_char_next  = pend_char;

    strobe_next      = 1'b0;
    cell_row_next    = '0;
    cell_column_next = '0;
    cell_char_next   = '0;
    status_next      = 1'b0;
    last_next        = 1'b0;

    cell_we     = 1'b0;
    cell_waddr  = sweep_addr;
    cell_wdata  = '0;
    drawn_we    = 1'b0;
    drawn_waddr = sweep_addr;
    drawn_wdata = '0;
    cell_raddr  = cell_base + AW'(col_cnt);
    drawn_raddr = drawn_base + AW'(col_cnt);

    case (state)
      ST_INIT, ST_WIPE: begin
        cell_we         = 1'b1;
        drawn_we        = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
      end
      ST_IDLE: begin
        if (pop) begin
          case (cmd.op)
            OP_PUT: begin
              cell_we    = 1'b1;
              cell_waddr = addr_of(phys_of(cur_row, top), cur_col);
              cell_wdata = cmd.ch;
              cur_col_next = at_col_end ? '0 : cur_col + 1'b1;
            end
            OP_NEWLINE, OP_RETURN: begin
              cur_col_next = '0;
            end
            OP_DELETE: begin
              cur_col_next = del_col;
              cur_row_next = del_row;
              cell_we      = 1'b1;
              cell_waddr   = addr_of(phys_of(del_row, top), del_col);
              cell_wdata   = CH_SPACE;
            end
            OP_SET_COL: begin
              cur_col_next = CW'(cmd.val);
            end
            OP_SET_ROW: begin
              cur_row_next = RW'(cmd.val);
            end
            OP_CLEAR: begin
              cur_col_next    = '0;
              cur_row_next    = '0;
              top_next        = '0;
              sweep_addr_next = '0;
            end
            OP_REFRESH: begin
              col_cnt_next    = '0;
              ref_row_next    = RW'(cmd.row);
              ref_lazy_next   = cmd.lazy;
              cell_base_next  = addr_of(phys_of(RW'(cmd.row), top), '0);
              drawn_base_next = addr_of(RW'(cmd.row), '0);
              pend_valid_next = 1'b0;
            end
            default: begin
            end
          endcase

          // A new line below the last row retires the oldest row: it
          // becomes the bottom row and is blanked column by column.
          if (line_feed) begin
            if (!at_row_end) begin
              cur_row_next = cur_row + 1'b1;
            end else begin
              top_next        = (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
              sweep_addr_next = addr_of(top, '0);
              col_cnt_next    = '0;
            end
          end

          if (cmd.op != OP_REFRESH) begin
            strobe_next = 1'b1;
            status_next = (cmd.op == OP_BAD_CURSOR);
            last_next   = 1'b1;
          end
        end
      end
      ST_SCROLL: begin
        cell_we         = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        col_cnt_next    = col_cnt + 1'b1;
      end
      ST_REFRESH: begin
        rd_valid_next = 1'b1;
        rd_col_next   = col_cnt;
        col_cnt_next  = col_cnt + 1'b1;
      end
      ST_DRAIN: begin
        if (pend_valid) begin
          strobe_next      = 1'b1;
          cell_row_next    = OUT_ROW_W'(ref_row);
          cell_column_next = OUT_COL_W'(pend_col);
          cell_char_next   = pend_char;
          last_next        = 1'b1;
        end
        pend_valid_next = 1'b0;
      end
      default: begin
      end
    endcase

    // Refresh compare stage: one column of both stores arrives each cycle.
    // The newest emitted cell is held back one step so that the final one
    // can carry the last flag.
    if (rd_valid && hit) begin
      drawn_we    = 1'b1;
      drawn_waddr = drawn_base + AW'(rd_col);
      drawn_wdata = cell_rdata;
      if (pend_valid) begin
        strobe_next      = 1'b1;
        cell_row_next    = OUT_ROW_W'(ref_row);
        cell_column_next = OUT_COL_W'(pend_col);
        cell_char_next   = pend_char;
      end
      pend_valid_next = 1'b1;
      pend_col_next   = rd_col;
      pend_char_next  = cell_rdata;
    end
  end

  assign init_busy = (state == ST_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      sweep_addr <= '0;
      col_cnt    <= '0;
      ref_lazy   <= 1'b0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      top        <= top_next;
      sweep_addr <= sweep_addr_next;
      col_cnt    <= col_cnt_next;
      ref_lazy   <= ref_lazy_next;
      rd_valid   <= rd_valid_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ref_row     <= ref_row_next;
    cell_base   <= cell_base_next;
    drawn_base  <= drawn_base_next;
    rd_col      <= rd_col_next;
    pend_col    <= pend_col_next;
    pend_char   <= pend_char_next;
    cell_row    <= cell_row_next;
    cell_column <= cell_column_next;
    cell_char   <= cell_char_next;
    status      <= status_next;
    last        <= last_next;
  end

  `TTCB_ASSERT(a_cursor_col_range, cur_col <= CW'(COLUMNS - 1), "cursor column out of range")
  `TTCB_ASSERT(a_top_range, top <= RW'(ROWS - 1), "ring top row out of range")
  `TTCB_ASSERT(a_more_follows, (strobe && !last) |-> (state == ST_REFRESH || state == ST_TAIL || state == ST_DRAIN), "non-final result with no refresh under way")

endmodule

>>> hdl/text_terminal_cell_buffer.sv
// Top level of the character-cell terminal buffer engine.
// Depends on ttcb_pkg, ttcb_front, ttcb_cmd_fifo and ttcb_back.
//
//   Channel   Handshake            Payload ports
//   -------   ------------------   --------------------------------------------------
//   item in   start, busy          mode, char_code, row_index, lazy, cursor_value
//   result    strobe (no stall)    cell_row, cell_column, cell_char, status, last
//
// An item is taken at a rising edge with start high and busy low. The front end
// classifies it in the same cycle and writes a command into a two-entry queue.
// The back end runs one command at a time: a put, cursor set or bad cursor value
// is done in the idle state, then a row is blanked when a new line scrolls the
// screen; a refresh reads one column of both stores per cycle through the single
// read port of each store, then passes the tail and drain states; a clear sweeps
// every cell of both stores. After reset the block holds busy high while it writes
// zero into every cell of both stores. Results cannot be stalled: each one is on
// the result ports for exactly one cycle, marked by strobe.
module text_terminal_cell_buffer #(
  parameter int COLUMNS = ttcb_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcb_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ttcb_pkg::MODE_W-1:0]    mode,
  input  logic [ttcb_pkg::CHAR_W-1:0]    char_code,
  input  logic [ttcb_pkg::IN_ROW_W-1:0]  row_index,
  input  logic                           lazy,
  input  logic signed [7:0]              cursor_value,
  output logic                           strobe,
  output logic [ttcb_pkg::OUT_ROW_W-1:0] cell_row,
  output logic [ttcb_pkg::OUT_COL_W-1:0] cell_column,
  output logic [ttcb_pkg::CHAR_W-1:0]    cell_char,
  output logic                           status,
  output logic                           last
);

  import ttcb_pkg::*;

  // Front end to queue.
  logic queue_full;
  logic push;
  cmd_t push_cmd;

  // Queue to back end.
  logic queue_empty;
  logic pop;
  cmd_t head_cmd;

  // Back end holds the front off during the power-up clearing sweep.
  logic init_busy;

  ttcb_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .start        (start),
    .mode         (mode),
    .char_code    (char_code),
    .row_index    (row_index),
    .lazy         (lazy),
    .cursor_value (cursor_value),
    .queue_full   (queue_full),
    .init_busy    (init_busy),
    .busy         (busy),
    .push         (push),
    .cmd          (push_cmd)
  );

  // The queue lets the front keep taking items while the back end scrolls,
  // clears or walks a row.
  ttcb_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .full  (queue_full),
    .pop   (pop),
    .dout  (head_cmd),
    .empty (queue_empty)
  );

  // The back end owns the cursor, both character stores and the result register.
  ttcb_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (queue_empty),
    .cmd         (head_cmd),
    .pop         (pop),
    .init_busy   (init_busy),
    .strobe      (strobe),
    .cell_row    (cell_row),
    .cell_column (cell_column),
    .cell_char   (cell_char),
    .status      (status),
    .last        (last)
  );

endmodule
